// ===== rtl/scl_pkg.sv =====
package scl_pkg;

   localparam logic [12:0] ATTR_BASE     = 13'h1800;
   localparam logic [7:0]  LAND_X_ORIGIN = 8'd215;
   localparam logic [7:0]  LAND_Y_OFFSET = 8'd16;
   localparam logic [7:0]  PAIR_WIDTH    = 8'd15;
   localparam logic [7:0]  ODD_OFFSET    = 8'd8;
   localparam logic [2:0]  LAST_EVEN     = 3'd7;
   localparam logic [2:0]  LAST_ODD      = 3'd6;

   typedef struct packed {
      logic [12:0] bitmap_address;
      logic [12:0] attribute_address;
      logic [3:0]  ink;
      logic [3:0]  paper;
      logic [7:0]  pixel_bits;
      logic [7:0]  fixed_coord;
      logic [7:0]  run_start;
      logic        landscape;
      logic        odd;
   } cell_item_type;

endpackage

// ===== rtl/scl_front.sv =====
module scl_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_orientation,
   input  logic [4:0]             cell_row,
   input  logic [4:0]             cell_col,
   input  logic [2:0]             line_in_cell,
   input  logic [7:0]             pixel_bits,
   input  logic [7:0]             attribute,
   input  logic                   flash_phase,
   output scl_pkg::cell_item_type item
);
   import scl_pkg::*;

   logic       orientation_ff, orientation_in;
   logic [7:0] vline;
   logic [7:0] left;
   logic [3:0] ink_raw, paper_raw;
   logic       swap;

   assign csr_ready = 1'b1;

   always_comb begin
      orientation_in = orientation_ff;
      if (csr_valid) begin
         orientation_in = csr_orientation;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         orientation_ff <= 1'b0;
      end else begin
         orientation_ff <= orientation_in;
      end
   end

   always_comb begin
      vline     = {cell_row, line_in_cell};
      left      = ({cell_col[4:1], 4'b0000} - {4'b0000, cell_col[4:1]})
                  + (cell_col[0] ? ODD_OFFSET : 8'd0);
      ink_raw   = {attribute[6], attribute[2:0]};
      paper_raw = {attribute[6], attribute[5:3]};
      swap      = attribute[7] & flash_phase;

      item.bitmap_address    = {cell_row[4:3], line_in_cell, cell_row[2:0], cell_col};
      item.attribute_address = ATTR_BASE | {3'b000, cell_row, cell_col};
      item.ink               = swap ? paper_raw : ink_raw;
      item.paper             = swap ? ink_raw : paper_raw;
      item.pixel_bits        = pixel_bits;
      item.landscape         = orientation_ff;
      item.odd               = cell_col[0];
      if (orientation_ff) begin
         item.fixed_coord = LAND_X_ORIGIN - vline;
         item.run_start   = LAND_Y_OFFSET + left;
      end else begin
         item.fixed_coord = vline;
         item.run_start   = left;
      end
   end

endmodule

// ===== rtl/scl_queue.sv =====
module scl_queue #(
   parameter int DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  scl_pkg::cell_item_type push_item,
   output logic                   full,
   input  logic                   pop,
   output logic                   head_valid,
   output scl_pkg::cell_item_type head_item
);
   import scl_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   cell_item_type slots_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full       = (count_ff == FULL_COUNT);
   assign head_valid = (count_ff != '0);
   assign head_item  = slots_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/scl_back.sv =====
module scl_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  scl_pkg::cell_item_type head_item,
   output logic                   head_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [7:0]             rsp_screen_x,
   output logic [7:0]             rsp_screen_y,
   output logic [3:0]             rsp_color_index,
   output logic [12:0]            rsp_bitmap_address,
   output logic [12:0]            rsp_attribute_address,
   output logic                   rsp_last
);
   import scl_pkg::*;

   logic        out_valid_ff, out_valid_in;
   logic [2:0]  pix_ff, pix_in;
   logic        load;
   logic        pix_last;
   logic        pix_set;
   logic [7:0]  along;
   logic [7:0]  x_ff, x_in, y_ff, y_in;
   logic [3:0]  color_ff, color_in;
   logic [12:0] bmp_ff, att_ff;
   logic        last_ff;

   assign load     = head_valid & (~out_valid_ff | rsp_pop);
   assign pix_last = (pix_ff == (head_item.odd ? LAST_ODD : LAST_EVEN));
   assign head_pop = load & pix_last;

   always_comb begin
      along    = head_item.run_start + {5'b00000, pix_ff};
      pix_set  = head_item.pixel_bits[LAST_EVEN - pix_ff];
      color_in = pix_set ? head_item.ink : head_item.paper;
      if (head_item.landscape) begin
         x_in = head_item.fixed_coord;
         y_in = along;
      end else begin
         x_in = along;
         y_in = head_item.fixed_coord;
      end
      pix_in       = pix_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         pix_in       = pix_last ? 3'd0 : pix_ff + 3'd1;
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pix_ff       <= 3'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         pix_ff       <= pix_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         color_ff <= color_in;
         bmp_ff   <= head_item.bitmap_address;
         att_ff   <= head_item.attribute_address;
         last_ff  <= pix_last;
      end
   end

   assign rsp_empty             = ~out_valid_ff;
   assign rsp_screen_x          = x_ff;
   assign rsp_screen_y          = y_ff;
   assign rsp_color_index       = color_ff;
   assign rsp_bitmap_address    = bmp_ff;
   assign rsp_attribute_address = att_ff;
   assign rsp_last              = last_ff;

   // pixel counter only advances over a live queue head
   a_idle_counter: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> pix_ff == 3'd0)
      else $error("pixel counter nonzero without a queued cell");

   a_odd_short: assert property (@(posedge clock) disable iff (reset)
      head_valid && head_item.odd |-> pix_ff != LAST_EVEN)
      else $error("odd column ran to an eighth pixel");

   a_pop_restart: assert property (@(posedge clock) disable iff (reset)
      head_pop |=> pix_ff == 3'd0)
      else $error("counter not restarted after queue pop");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_last == $past(head_pop))
      else $error("last flag out of step with queue pop");

endmodule

// ===== rtl/spectrum_cell_line_render.sv =====
// Channel   Direction  Handshake            Payload
// req_      in         req_push / req_full  cell row, column, line, bitmap, attribute, phase
// rsp_      out        rsp_empty / rsp_pop  x, y, color index, addresses, last
// csr_      in         csr_valid / csr_ready orientation
//
// One pixel per cycle unless rsp_pop stalls: a cell line has 8 pixels (7 for odd columns),
// set by the single pixel counter in the back end walking the queue head.
// A request is taken whenever the cell queue has room, also while results wait.
// Reset (synchronous) empties the queue and output register, orientation -> 0.
// A stalled rsp_pop holds the output register; the queue then fills and raises req_full.
module spectrum_cell_line_render #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_orientation,
   input  logic        req_push,
   output logic        req_full,
   input  logic [4:0]  req_cell_row,
   input  logic [4:0]  req_cell_col,
   input  logic [2:0]  req_line_in_cell,
   input  logic [7:0]  req_pixel_bits,
   input  logic [7:0]  req_attribute,
   input  logic        req_flash_phase,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_screen_x,
   output logic [7:0]  rsp_screen_y,
   output logic [3:0]  rsp_color_index,
   output logic [12:0] rsp_bitmap_address,
   output logic [12:0] rsp_attribute_address,
   output logic        rsp_last
);
   import scl_pkg::*;

   cell_item_type front_item;
   cell_item_type head_item;
   logic          head_valid;
   logic          head_pop;

   scl_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_orientation (csr_orientation),
      .cell_row        (req_cell_row),
      .cell_col        (req_cell_col),
      .line_in_cell    (req_line_in_cell),
      .pixel_bits      (req_pixel_bits),
      .attribute       (req_attribute),
      .flash_phase     (req_flash_phase),
      .item            (front_item)
   );

   scl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .push_item  (front_item),
      .full       (req_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   scl_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .head_valid            (head_valid),
      .head_item             (head_item),
      .head_pop              (head_pop),
      .rsp_empty             (rsp_empty),
      .rsp_pop               (rsp_pop),
      .rsp_screen_x          (rsp_screen_x),
      .rsp_screen_y          (rsp_screen_y),
      .rsp_color_index       (rsp_color_index),
      .rsp_bitmap_address    (rsp_bitmap_address),
      .rsp_attribute_address (rsp_attribute_address),
      .rsp_last              (rsp_last)
   );

endmodule
